// ===== hw/rtl/osc_message_serializer_unit_defines.svh =====
// Assertion helpers for the checker file of the message serializer.
`ifndef OSC_MESSAGE_SERIALIZER_UNIT_DEFINES_SVH
`define OSC_MESSAGE_SERIALIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serializer check failed");

// The consequent must hold in the cycle after the antecedent.
`define OMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serializer check failed");

`endif

// ===== hw/rtl/oms_pkg.sv =====
`default_nettype none
package oms_pkg;

  localparam int unsigned CAP_W = 16;
  // Upper bound applied to the capacity register.
  localparam logic [23:0] MAX_CAPACITY = 24'd65535;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;
  localparam logic [7:0] COMMA = 8'h2C;
  localparam logic [1:0] ALIGN_MASK = 2'h3;
  localparam int unsigned MAX_RESULTS = 5;

  typedef enum logic [2:0] {
    REQ_START     = 3'd0,
    REQ_ADDR_BYTE = 3'd1,
    REQ_TAG_BYTE  = 3'd2,
    REQ_STR_BYTE  = 3'd3,
    REQ_WORD      = 3'd4,
    REQ_BLOB_LEN  = 3'd5,
    REQ_BLOB_BYTE = 3'd6,
    REQ_FINISH    = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_TAGS = 2'd1,
    PH_ARGS = 2'd2,
    PH_IDLE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ALIGN    = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  in_byte;
    logic [31:0] word_value;
  } item_t;

  typedef struct packed {
    logic [15:0] used;
    phase_t      phase;
    logic [15:0] blob_left;
    status_t     abort_code;
  } ctx_t;

  // Everything one token produces: its message bytes, then an optional byte-less result.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [2:0]                  nbytes;
    logic                        trailer;
    status_t                     trail_status;
    logic [15:0]                 base;
    logic [15:0]                 final_size;
  } plan_t;

endpackage
`default_nettype wire

// ===== hw/rtl/oms_in_stage.sv =====
`default_nettype none
module oms_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire oms_pkg::item_t in_item,
  input  wire logic          take,
  output logic               held_valid,
  output oms_pkg::item_t     held_item
);

  logic full;
  oms_pkg::item_t item;

  assign in_ready   = !full || take;
  assign held_valid = full;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oms_plan.sv =====
`default_nettype none
module oms_plan (
  input  wire oms_pkg::item_t     item,
  input  wire oms_pkg::ctx_t      ctx,
  input  wire logic [15:0]        cap,
  output oms_pkg::ctx_t           ctx_next,
  output oms_pkg::plan_t          plan
);

  oms_pkg::req_t req;
  logic          changed;
  logic          cap_bad;
  logic          has_room;
  logic [15:0]   room;
  logic          aligned;
  logic          args_ok;
  logic [15:0]   s1;
  logic [1:0]    pad;
  logic [15:0]   s_pad;
  logic          term;
  logic [2:0]    str_n;
  logic [15:0]   str_used;
  logic [15:0]   blob_dec;

  always_comb begin
    req      = oms_pkg::req_t'(item.req);
    cap_bad  = (cap & {14'd0, oms_pkg::ALIGN_MASK}) != 16'd0;
    has_room = cap > ctx.used;
    room     = has_room ? cap - ctx.used : 16'd0;
    aligned  = (ctx.used[1:0] & oms_pkg::ALIGN_MASK) == 2'd0;
    args_ok  = ctx.phase == oms_pkg::PH_ARGS && ctx.blob_left == 16'd0;
    s1       = ctx.used + 16'd1;
    // Zero bytes needed after the next byte to reach four-byte alignment.
    pad      = 2'(3'd4 - {1'b0, s1[1:0]});
    s_pad    = s1 + {14'd0, pad};
    term     = item.in_byte == 8'd0;
    str_n    = term ? 3'd1 + {1'b0, pad} : 3'd1;
    str_used = term ? s_pad : s1;
    blob_dec = ctx.blob_left - 16'd1;

    ctx_next = ctx;
    plan     = '0;
    changed  = 1'b0;
    plan.base = ctx.used;

    if (req == oms_pkg::REQ_START) begin
      ctx_next.used       = 16'd0;
      ctx_next.blob_left  = 16'd0;
      ctx_next.phase      = oms_pkg::PH_ADDR;
      ctx_next.abort_code = cap_bad ? oms_pkg::ST_ALIGN : oms_pkg::ST_OK;
    end else if (ctx.abort_code != oms_pkg::ST_OK || ctx.phase == oms_pkg::PH_IDLE) begin
      if (req == oms_pkg::REQ_FINISH) begin
        ctx_next.phase = oms_pkg::PH_IDLE;
      end
    end else if (cap_bad) begin
      ctx_next.abort_code = oms_pkg::ST_ALIGN;
      changed = 1'b1;
    end else begin
      case (req)
        oms_pkg::REQ_FINISH: begin
          ctx_next.phase = oms_pkg::PH_IDLE;
        end
        oms_pkg::REQ_ADDR_BYTE: begin
          if (ctx.phase == oms_pkg::PH_ADDR) begin
            if (!has_room) begin
              ctx_next.abort_code = oms_pkg::ST_OVERFLOW;
              changed = 1'b1;
            end else begin
              plan.bytes[0] = item.in_byte;
              plan.nbytes   = str_n;
              ctx_next.used = str_used;
              if (term) begin
                if (cap <= s_pad) begin
                  ctx_next.abort_code = oms_pkg::ST_OVERFLOW;
                  changed = 1'b1;
                end else begin
                  // The comma that opens the type tags follows the padded address.
                  plan.bytes[3'd1 + {1'b0, pad}] = oms_pkg::COMMA;
                  plan.nbytes    = str_n + 3'd1;
                  ctx_next.used  = s_pad + 16'd1;
                  ctx_next.phase = oms_pkg::PH_TAGS;
                end
              end
            end
          end
        end
        oms_pkg::REQ_TAG_BYTE, oms_pkg::REQ_STR_BYTE: begin
          if ((req == oms_pkg::REQ_TAG_BYTE && ctx.phase == oms_pkg::PH_TAGS) ||
              (req == oms_pkg::REQ_STR_BYTE && args_ok)) begin
            if (!has_room) begin
              ctx_next.abort_code = oms_pkg::ST_OVERFLOW;
              changed = 1'b1;
            end else begin
              plan.bytes[0] = item.in_byte;
              plan.nbytes   = str_n;
              ctx_next.used = str_used;
              if (term && req == oms_pkg::REQ_TAG_BYTE) begin
                ctx_next.phase = oms_pkg::PH_ARGS;
              end
            end
          end
        end
        oms_pkg::REQ_WORD, oms_pkg::REQ_BLOB_LEN: begin
          if (args_ok && aligned) begin
            if ((req == oms_pkg::REQ_WORD && room < 16'd4) ||
                (req == oms_pkg::REQ_BLOB_LEN &&
                 ({1'b0, item.word_value} + 33'd4) > {17'd0, room})) begin
              ctx_next.abort_code = oms_pkg::ST_OVERFLOW;
              changed = 1'b1;
            end else begin
              plan.bytes[0] = item.word_value[31:24];
              plan.bytes[1] = item.word_value[23:16];
              plan.bytes[2] = item.word_value[15:8];
              plan.bytes[3] = item.word_value[7:0];
              plan.nbytes   = 3'd4;
              ctx_next.used = ctx.used + 16'd4;
              if (req == oms_pkg::REQ_BLOB_LEN) begin
                ctx_next.blob_left = item.word_value[15:0];
              end
            end
          end
        end
        oms_pkg::REQ_BLOB_BYTE: begin
          if (ctx.phase == oms_pkg::PH_ARGS && ctx.blob_left != 16'd0) begin
            if (!has_room) begin
              ctx_next.abort_code = oms_pkg::ST_OVERFLOW;
              changed = 1'b1;
            end else begin
              plan.bytes[0]      = item.in_byte;
              ctx_next.blob_left = blob_dec;
              // The final blob byte is followed by padding to alignment.
              if (blob_dec == 16'd0) begin
                plan.nbytes   = 3'd1 + {1'b0, pad};
                ctx_next.used = s_pad;
              end else begin
                plan.nbytes   = 3'd1;
                ctx_next.used = s1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    plan.trailer      = plan.nbytes == 3'd0 || changed;
    plan.trail_status = ctx_next.abort_code;
    plan.final_size   = ctx_next.used;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oms_out_stage.sv =====
`default_nettype none
module oms_out_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire oms_pkg::plan_t plan_in,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                last,
  output logic [1:0]          status,
  output logic [15:0]         message_size
);

  logic           busy;
  logic [2:0]     idx;
  oms_pkg::plan_t plan;
  logic [2:0]     total;
  logic           is_byte;
  logic           done;

  always_comb begin
    total        = plan.nbytes + {2'd0, plan.trailer};
    is_byte      = idx < plan.nbytes;
    last         = idx == total - 3'd1;
    out_valid    = busy;
    has_byte     = is_byte;
    out_byte     = is_byte ? plan.bytes[idx] : 8'd0;
    status       = is_byte ? oms_pkg::ST_OK : plan.trail_status;
    message_size = is_byte ? plan.base + {13'd0, idx} + 16'd1 : plan.final_size;
    done         = busy && out_ready && last;
    free         = !busy || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plan <= plan_in;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/osc_message_serializer_unit.sv =====
`default_nettype none
// Streaming encoder for Open Sound Control 1.0 messages. Each slave transaction is one
// token (tuser: start, address byte, type-tag byte, string byte, word, blob length,
// blob byte, finish) and yields one to five master transactions, the final one with
// tlast set. Message bytes carry tuser 1; a byte-less transaction (tuser 0) reports
// status and size for tokens that emit nothing or that abort the message. A token is
// held in an input register, encoded in one pass of logic and moved into the output
// register, so with m_tready high and one result per token a new token is taken every
// cycle; a token with several results holds the output register until its last result
// is taken. Capacity (cfg_wdata, reset 1024 bytes) is sampled as each token is encoded
// and must be a multiple of four.
module osc_message_serializer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata,     // packet_capacity
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,       // in_byte[7:0], word_value[39:8]
  input  wire logic [2:0]  s_tuser,       // req_type[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,       // out_byte[7:0], status[9:8], message_size[25:10]
  output logic             m_tuser,       // has_byte[0]
  output logic             m_tlast
);

  logic [15:0]    packet_capacity;
  logic [15:0]    cap;
  oms_pkg::ctx_t  ctx;
  oms_pkg::ctx_t  ctx_next;
  oms_pkg::item_t in_item;
  oms_pkg::item_t held_item;
  oms_pkg::plan_t plan;
  logic           held_valid;
  logic           free;
  logic           take;
  logic [7:0]     out_byte;
  logic [1:0]     status;
  logic [15:0]    message_size;

  assign in_item.req        = s_tuser;
  assign in_item.in_byte    = s_tdata[7:0];
  assign in_item.word_value = s_tdata[39:8];

  assign cap  = ({8'd0, packet_capacity} > oms_pkg::MAX_CAPACITY) ?
                oms_pkg::MAX_CAPACITY[15:0] : packet_capacity;
  assign take = held_valid && free;

  assign m_tdata = {6'd0, message_size, status, out_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_capacity <= oms_pkg::CAP_RESET;
    end else if (cfg_wen) begin
      packet_capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.used       <= 16'd0;
      ctx.phase      <= oms_pkg::PH_ADDR;
      ctx.blob_left  <= 16'd0;
      ctx.abort_code <= oms_pkg::ST_OK;
    end else if (take) begin
      ctx <= ctx_next;
    end
  end

  oms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  oms_plan u_plan (
    .item     (held_item),
    .ctx      (ctx),
    .cap      (cap),
    .ctx_next (ctx_next),
    .plan     (plan)
  );

  oms_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .plan_in      (plan),
    .free         (free),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (out_byte),
    .has_byte     (m_tuser),
    .last         (m_tlast),
    .status       (status),
    .message_size (message_size)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/oms_checker.sv =====
`default_nettype none
`include "osc_message_serializer_unit_defines.svh"
module oms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // A result without a message byte always shows a zero byte.
  `OMS_ASSERT_NOW(a_empty_byte_zero, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)
  // Message bytes always carry an OK status.
  `OMS_ASSERT_NOW(a_byte_status_ok, m_tvalid && m_tuser, m_tdata[9:8] == 2'd0)
  `OMS_ASSERT_NOW(a_status_legal, m_tvalid, m_tdata[9:8] != 2'd3)
  // A stalled result stays on offer unchanged.
  `OMS_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind osc_message_serializer_unit oms_checker u_oms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
